### rtl/gamt_pkg.sv
package gamt_pkg;

  typedef enum logic [3:0] {
    REQ_ADD_VERTEX  = 4'd0,
    REQ_ADD_EDGE    = 4'd1,
    REQ_DEL_VERTEX  = 4'd2,
    REQ_DEL_EDGE    = 4'd3,
    REQ_EDIT_MARK   = 4'd4,
    REQ_EDIT_WEIGHT = 4'd5,
    REQ_FIRST       = 4'd6,
    REQ_NEXT        = 4'd7,
    REQ_KTH         = 4'd8
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MODIFY,
    ST_LOAD,
    ST_SCAN,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic adj;
    logic wgt;
    logic mark;
  } mem_we_t;

  localparam int unsigned FieldW = 5;
  localparam int unsigned InW    = 16;

endpackage

### rtl/gamt_store.sv
module gamt_store #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned IW           = 5
) (
  input  logic                    clk_i,
  input  gamt_pkg::mem_we_t       we_i,
  input  logic [IW-1:0]           adj_raddr_i,
  input  logic [IW-1:0]           adj_waddr_i,
  input  logic [MAX_VERTICES-1:0] adj_wdata_i,
  output logic [MAX_VERTICES-1:0] adj_rdata_o,
  input  logic [2*IW-1:0]         wgt_raddr_i,
  input  logic [2*IW-1:0]         wgt_waddr_i,
  input  logic [VALUE_BITS-1:0]   wgt_wdata_i,
  output logic [VALUE_BITS-1:0]   wgt_rdata_o,
  input  logic [IW-1:0]           mark_raddr_i,
  input  logic [IW-1:0]           mark_waddr_i,
  input  logic [VALUE_BITS-1:0]   mark_wdata_i,
  output logic [VALUE_BITS-1:0]   mark_rdata_o
);
  import gamt_pkg::*;

  logic [MAX_VERTICES-1:0] adj_mem  [1<<IW];
  logic [VALUE_BITS-1:0]   wgt_mem  [1<<(2*IW)];
  logic [VALUE_BITS-1:0]   mark_mem [1<<IW];

  always_ff @(posedge clk_i) begin
    if (we_i.adj) adj_mem[adj_waddr_i] <= adj_wdata_i;
    adj_rdata_o <= adj_mem[adj_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.wgt) wgt_mem[wgt_waddr_i] <= wgt_wdata_i;
    wgt_rdata_o <= wgt_mem[wgt_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.mark) mark_mem[mark_waddr_i] <= mark_wdata_i;
    mark_rdata_o <= mark_mem[mark_raddr_i];
  end

endmodule

### rtl/gamt_ctrl.sv
module gamt_ctrl #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned VALUE_BITS   = 16,
  parameter int unsigned IW           = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3:0]              req_i,
  input  logic [4:0]              vertex_i,
  input  logic [4:0]              other_i,
  input  logic [4:0]              position_i,
  input  logic signed [15:0]      weight_i,
  input  logic signed [15:0]      mark_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    status_o,
  output logic                    found_o,
  output logic [4:0]              neighbour_o,
  output gamt_pkg::mem_we_t       we_o,
  output logic [IW-1:0]           adj_raddr_o,
  output logic [IW-1:0]           adj_waddr_o,
  output logic [MAX_VERTICES-1:0] adj_wdata_o,
  input  logic [MAX_VERTICES-1:0] adj_rdata_i,
  output logic [2*IW-1:0]         wgt_raddr_o,
  output logic [2*IW-1:0]         wgt_waddr_o,
  output logic [VALUE_BITS-1:0]   wgt_wdata_o,
  input  logic [VALUE_BITS-1:0]   wgt_rdata_i,
  output logic [IW-1:0]           mark_raddr_o,
  output logic [IW-1:0]           mark_waddr_o,
  output logic [VALUE_BITS-1:0]   mark_wdata_o,
  input  logic [VALUE_BITS-1:0]   mark_rdata_i
);
  import gamt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW = (CW > FieldW) ? CW : FieldW;
  localparam logic [MAX_VERTICES-1:0] Ones = {MAX_VERTICES{1'b1}};

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  req_e req_q, req_d;
  logic [4:0] v_q, v_d, e_q, e_d, pos_q, pos_d, rank_q, rank_d;
  logic signed [InW-1:0] w_q, w_d, m_q, m_d;
  logic [MAX_VERTICES-1:0] row_q, row_d;
  logic [IW-1:0] r_q, r_d, c_q, c_d, pw_r_q, pw_r_d, pw_c_q, pw_c_d;
  logic last_q, last_d, pw_q, pw_d, pw_zr_q, pw_zr_d, pw_zc_q, pw_zc_d;
  logic res_st_q, res_st_d, res_fd_q, res_fd_d;
  logic [4:0] res_nb_q, res_nb_d;
  logic ov_q, ov_d, os_q, os_d, of_q, of_d;
  logic [4:0] on_q, on_d;

  logic [XW-1:0] v_x, e_x, pos_x, n_x;
  logic v_ok, e_ok, pos_ok, v_app, full;
  logic [IW-1:0] v_idx, e_idx, n1, low_idx;
  logic [IW:0] rs, cs;
  logic zr, zc;
  logic [MAX_VERTICES-1:0] nmask, lowm, low_bit, dropped;

  assign v_x    = XW'(v_q);
  assign e_x    = XW'(e_q);
  assign pos_x  = XW'(pos_q);
  assign n_x    = XW'(cnt_q);
  assign v_ok   = v_x < n_x;
  assign e_ok   = e_x < n_x;
  assign pos_ok = pos_x < n_x;
  assign v_app  = v_x == n_x;
  assign full   = cnt_q == CW'(MAX_VERTICES);
  assign v_idx  = v_x[IW-1:0];
  assign e_idx  = e_x[IW-1:0];
  assign n1     = IW'(cnt_q - 1'b1);
  assign nmask  = ~(Ones << cnt_q);

  assign rs = {1'b0, r_q} + (IW+1)'(r_q >= v_idx);
  assign cs = {1'b0, c_q} + (IW+1)'(c_q >= v_idx);
  assign zr = r_q == n1;
  assign zc = c_q == n1;

  assign lowm    = ~(Ones << v_idx);
  assign dropped = (adj_rdata_i & lowm) | ((adj_rdata_i >> 1) & ~lowm);

  assign low_bit = row_q & (~row_q + 1'b1);
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (low_bit[i]) low_idx = low_idx | IW'(i);
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = ov_q;
  assign status_o    = os_q;
  assign found_o     = of_q;
  assign neighbour_o = on_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    v_d      = v_q;
    e_d      = e_q;
    pos_d    = pos_q;
    w_d      = w_q;
    m_d      = m_q;
    rank_d   = rank_q;
    row_d    = row_q;
    r_d      = r_q;
    c_d      = c_q;
    last_d   = last_q;
    pw_d     = pw_q;
    pw_r_d   = pw_r_q;
    pw_c_d   = pw_c_q;
    pw_zr_d  = pw_zr_q;
    pw_zc_d  = pw_zc_q;
    res_st_d = res_st_q;
    res_fd_d = res_fd_q;
    res_nb_d = res_nb_q;
    ov_d     = ov_q & ~out_ready_i;
    os_d     = os_q;
    of_d     = of_q;
    on_d     = on_q;
    we_o     = '0;
    adj_raddr_o  = v_idx;
    adj_waddr_o  = v_idx;
    adj_wdata_o  = '0;
    wgt_raddr_o  = {rs[IW-1:0], cs[IW-1:0]};
    wgt_waddr_o  = {v_idx, e_idx};
    wgt_wdata_o  = VALUE_BITS'(w_q);
    mark_raddr_o = rs[IW-1:0];
    mark_waddr_o = v_idx;
    mark_wdata_o = VALUE_BITS'(m_q);

    unique case (state_q)
      ST_CLEAR: begin
        we_o.wgt    = 1'b1;
        wgt_waddr_o = {r_q, c_q};
        wgt_wdata_o = '0;
        adj_waddr_o = r_q;
        we_o.adj    = c_q == '0;
        c_d = c_q + 1'b1;
        if (&c_q) begin
          r_d = r_q + 1'b1;
          if (&r_q) state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_e'(req_i);
          v_d     = vertex_i;
          e_d     = other_i;
          pos_d   = position_i;
          w_d     = weight_i;
          m_d     = mark_i;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_st_d = 1'b0;
        res_fd_d = 1'b0;
        res_nb_d = '0;
        state_d  = ST_FINISH;
        case (req_q)
          REQ_ADD_VERTEX: begin
            if (v_ok) begin
              we_o.mark = 1'b1;
            end else if (v_app && !full) begin
              we_o.mark = 1'b1;
              cnt_d     = cnt_q + 1'b1;
            end else begin
              res_st_d = 1'b1;
            end
          end
          REQ_EDIT_MARK: begin
            if (v_ok) we_o.mark = 1'b1;
            else res_st_d = 1'b1;
          end
          REQ_ADD_EDGE, REQ_DEL_EDGE, REQ_EDIT_WEIGHT: begin
            if (v_ok && e_ok) begin
              we_o.wgt = 1'b1;
              if (req_q == REQ_DEL_EDGE) wgt_wdata_o = '0;
              if (req_q != REQ_EDIT_WEIGHT) state_d = ST_MODIFY;
            end else begin
              res_st_d = 1'b1;
            end
          end
          REQ_DEL_VERTEX: begin
            if (v_ok) begin
              r_d     = '0;
              c_d     = '0;
              last_d  = 1'b0;
              pw_d    = 1'b0;
              state_d = ST_SWEEP;
            end else begin
              res_st_d = 1'b1;
            end
          end
          REQ_FIRST, REQ_NEXT, REQ_KTH: begin
            if (v_ok && (req_q != REQ_NEXT || pos_ok)) state_d = ST_LOAD;
            else res_st_d = 1'b1;
          end
          default: res_st_d = 1'b1;
        endcase
      end
      ST_MODIFY: begin
        we_o.adj    = 1'b1;
        adj_wdata_o = (req_q == REQ_ADD_EDGE) ?
                      (adj_rdata_i | (MAX_VERTICES'(1) << e_idx)) :
                      (adj_rdata_i & ~(MAX_VERTICES'(1) << e_idx));
        state_d = ST_FINISH;
      end
      ST_LOAD: begin
        row_d = adj_rdata_i & nmask;
        if (req_q == REQ_NEXT) row_d = adj_rdata_i & nmask & ((Ones << pos_x) << 1);
        rank_d  = pos_q;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (row_q == '0) begin
          state_d = ST_FINISH;
        end else if (req_q != REQ_KTH || rank_q == '0) begin
          res_fd_d = 1'b1;
          res_nb_d = 5'(low_idx);
          state_d  = ST_FINISH;
        end else begin
          row_d  = row_q & ~low_bit;
          rank_d = rank_q - 1'b1;
        end
      end
      ST_SWEEP: begin
        adj_raddr_o = rs[IW-1:0];
        if (pw_q) begin
          we_o.wgt     = 1'b1;
          wgt_waddr_o  = {pw_r_q, pw_c_q};
          wgt_wdata_o  = (pw_zr_q || pw_zc_q) ? '0 : wgt_rdata_i;
          we_o.adj     = pw_c_q == '0;
          we_o.mark    = pw_c_q == '0;
          adj_waddr_o  = pw_r_q;
          adj_wdata_o  = pw_zr_q ? '0 : dropped;
          mark_waddr_o = pw_r_q;
          mark_wdata_o = mark_rdata_i;
        end
        if (!last_q) begin
          pw_d    = 1'b1;
          pw_r_d  = r_q;
          pw_c_d  = c_q;
          pw_zr_d = zr;
          pw_zc_d = zc;
          if (zc) begin
            c_d = '0;
            r_d = r_q + 1'b1;
            if (zr) last_d = 1'b1;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          pw_d = 1'b0;
          if (!pw_q) begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          os_d    = res_st_q;
          of_d    = res_fd_q;
          on_d    = res_nb_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      r_q     <= '0;
      c_q     <= '0;
      last_q  <= 1'b0;
      pw_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      c_q     <= c_d;
      last_q  <= last_d;
      pw_q    <= pw_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    v_q      <= v_d;
    e_q      <= e_d;
    pos_q    <= pos_d;
    w_q      <= w_d;
    m_q      <= m_d;
    rank_q   <= rank_d;
    row_q    <= row_d;
    pw_r_q   <= pw_r_d;
    pw_c_q   <= pw_c_d;
    pw_zr_q  <= pw_zr_d;
    pw_zc_q  <= pw_zc_d;
    res_st_q <= res_st_d;
    res_fd_q <= res_fd_d;
    res_nb_q <= res_nb_d;
    os_q     <= os_d;
    of_q     <= of_d;
    on_q     <= on_d;
  end

endmodule

### rtl/graph_adjacency_matrix_table_top.sv
// Directed graph store for up to MAX_VERTICES densely numbered vertices: an
// adjacency bit matrix, an edge weight matrix and a mark per vertex, all held
// in single-port-read, single-port-write memories with registered reads.
// One request in, one response out. After reset the block clears the weight
// and adjacency memories before taking requests. Edge add/delete does a
// read-modify-write of one adjacency row, neighbour queries load one
// adjacency row and scan it, stepping past each skipped neighbour for k-th,
// and delete vertex compacts the weight cells of n vertices, one weight
// cell copied per cycle. A finished response waits in the output register
// while the next request is taken.
module graph_adjacency_matrix_table_top #(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[3:0], vertex[8:4], other_vertex[13:9], position[18:14],
  // weight[34:19], mark[50:35]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[0], found[1], neighbour[6:2]
  output logic [7:0]  m_axis_tdata
);
  import gamt_pkg::*;

  localparam int unsigned IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  mem_we_t                 we;
  logic [IW-1:0]           adj_raddr, adj_waddr, mark_raddr, mark_waddr;
  logic [2*IW-1:0]         wgt_raddr, wgt_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic [VALUE_BITS-1:0]   wgt_wdata, wgt_rdata, mark_wdata, mark_rdata;
  logic                    status, found;
  logic [4:0]              neighbour;

  gamt_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .VALUE_BITS  (VALUE_BITS),
    .IW          (IW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_i        (s_axis_tdata[3:0]),
    .vertex_i     (s_axis_tdata[8:4]),
    .other_i      (s_axis_tdata[13:9]),
    .position_i   (s_axis_tdata[18:14]),
    .weight_i     (s_axis_tdata[34:19]),
    .mark_i       (s_axis_tdata[50:35]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .found_o      (found),
    .neighbour_o  (neighbour),
    .we_o         (we),
    .adj_raddr_o  (adj_raddr),
    .adj_waddr_o  (adj_waddr),
    .adj_wdata_o  (adj_wdata),
    .adj_rdata_i  (adj_rdata),
    .wgt_raddr_o  (wgt_raddr),
    .wgt_waddr_o  (wgt_waddr),
    .wgt_wdata_o  (wgt_wdata),
    .wgt_rdata_i  (wgt_rdata),
    .mark_raddr_o (mark_raddr),
    .mark_waddr_o (mark_waddr),
    .mark_wdata_o (mark_wdata),
    .mark_rdata_i (mark_rdata)
  );

  gamt_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .VALUE_BITS  (VALUE_BITS),
    .IW          (IW)
  ) u_store (
    .clk_i        (clk_i),
    .we_i         (we),
    .adj_raddr_i  (adj_raddr),
    .adj_waddr_i  (adj_waddr),
    .adj_wdata_i  (adj_wdata),
    .adj_rdata_o  (adj_rdata),
    .wgt_raddr_i  (wgt_raddr),
    .wgt_waddr_i  (wgt_waddr),
    .wgt_wdata_i  (wgt_wdata),
    .wgt_rdata_o  (wgt_rdata),
    .mark_raddr_i (mark_raddr),
    .mark_waddr_i (mark_waddr),
    .mark_wdata_i (mark_wdata),
    .mark_rdata_o (mark_rdata)
  );

  assign m_axis_tdata = {1'b0, neighbour, found, status};

endmodule
